// ===== hdl/skm_pkg.sv =====
// ----------------------------------------------------------------------------
// skm_pkg
// Shared types and codes for the sorted key map unit.
// ----------------------------------------------------------------------------
package skm_pkg;

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_DELETE  = 3'd1,
        CMD_FIND    = 3'd2,
        CMD_PICK    = 3'd3,
        CMD_ITERATE = 3'd4
    } cmd_t;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
    localparam logic [2:0] ST_FULL        = 3'd2;
    localparam logic [2:0] ST_ORDER       = 3'd3;
    localparam logic [2:0] ST_ZERO_HANDLE = 3'd4;
    localparam logic [2:0] ST_EMPTY       = 3'd5;

    localparam int MAX_RESULTS = 64;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,     // read last used key
        S_ADD_CHK,
        S_SRCH_RD,    // binary search: issue read of mid
        S_SRCH_CHK,   // compare mid key
        S_SRCH_HRD,   // read handle at hit
        S_SRCH_DONE,
        S_SQ_RD,      // compaction walk: read slot
        S_SQ_WR,      // compaction walk: move if live
        S_MOD,        // pick mod used (restoring division)
        S_PICK_RD,
        S_PICK_OUT,
        S_IT_RD,
        S_IT_CHK,
        S_EMIT        // single final result
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture command fields
        logic idx_last;    // address = used-1
        logic idx_mid;     // address = mid
        logic idx_walk;    // address = walk pointer
        logic idx_pick;    // address = remainder
        logic search_init;
        logic search_step;
        logic walk_init;
        logic walk_step;
        logic sq_move;     // write live entry to write pointer
        logic sq_finish;
        logic add_write;
        logic del_write;
        logic mod_init;
        logic mod_step;
        logic out_emit;
        logic [2:0] out_status;
        logic out_use_handle; // drive found_handle from handle read data
        logic out_use_key;    // drive found_key from key read data
        logic out_last;
        logic it_count;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic used_zero;
        logic used_full;
        logic dead_over;
        logic no_live;
        logic has_dead;
        logic key_le;       // read key >= input key
        logic handle_zero;  // input handle zero
        logic rd_handle_zero;
        logic search_done;  // lo >= hi
        logic mk_lt;
        logic mk_eq;
        logic walk_done;
        logic mod_done;
        logic it_cap;       // 63 results already emitted
        logic it_final;     // next iterate result is the last live entry
    } sts_t;

endpackage

// ===== hdl/skm_ram.sv =====
// ----------------------------------------------------------------------------
// skm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module skm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hdl/skm_ctrl.sv =====
// ----------------------------------------------------------------------------
// skm_ctrl
// Command sequencer for the sorted key map.
// ----------------------------------------------------------------------------
module skm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [2:0]    command,
    input  skm_pkg::sts_t sts,
    output skm_pkg::ctl_t ctl,
    output logic          busy
);
    skm_pkg::state_t state_reg, state_next;
    logic [2:0] cmd_reg, cmd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skm_pkg::S_IDLE;
            cmd_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign busy = (state_reg != skm_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        ctl        = '0;
        case (state_reg)
            skm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    cmd_next = command;
                    case (command)
                        skm_pkg::CMD_ADD:
                        begin
                            ctl.idx_last = 1'b1;
                            state_next   = skm_pkg::S_ADD_RD;
                        end
                        skm_pkg::CMD_DELETE, skm_pkg::CMD_FIND:
                        begin
                            ctl.search_init = 1'b1;
                            state_next      = skm_pkg::S_SRCH_RD;
                        end
                        skm_pkg::CMD_PICK:
                        begin
                            ctl.walk_init = 1'b1;
                            state_next    = skm_pkg::S_SQ_RD;
                        end
                        skm_pkg::CMD_ITERATE:
                        begin
                            ctl.walk_init = 1'b1;
                            state_next    = skm_pkg::S_IT_RD;
                        end
                        default:
                        begin
                            state_next = skm_pkg::S_EMIT;
                        end
                    endcase
                end
            end
            skm_pkg::S_ADD_RD:
            begin
                ctl.idx_last = 1'b1;
                state_next   = skm_pkg::S_ADD_CHK;
            end
            skm_pkg::S_ADD_CHK:
            begin
                state_next     = skm_pkg::S_IDLE;
                ctl.out_emit   = 1'b1;
                ctl.out_last   = 1'b1;
                if (!sts.used_zero && sts.key_le)
                begin
                    ctl.out_status = skm_pkg::ST_ORDER;
                end
                else if (sts.handle_zero)
                begin
                    ctl.out_status = skm_pkg::ST_ZERO_HANDLE;
                end
                else if (sts.used_full && !sts.dead_over)
                begin
                    ctl.out_status = skm_pkg::ST_FULL;
                end
                else if (sts.used_full)
                begin
                    // compact first, then retry the append
                    ctl.out_emit  = 1'b0;
                    ctl.walk_init = 1'b1;
                    state_next    = skm_pkg::S_SQ_RD;
                end
                else
                begin
                    ctl.add_write  = 1'b1;
                    ctl.out_status = skm_pkg::ST_OK;
                end
            end
            skm_pkg::S_SRCH_RD:
            begin
                ctl.idx_mid = 1'b1;
                if (sts.search_done)
                begin
                    state_next = skm_pkg::S_EMIT;
                end
                else
                begin
                    state_next = skm_pkg::S_SRCH_CHK;
                end
            end
            skm_pkg::S_SRCH_CHK:
            begin
                ctl.idx_mid = 1'b1;
                if (sts.mk_eq)
                begin
                    state_next = skm_pkg::S_SRCH_HRD;
                end
                else
                begin
                    ctl.search_step = 1'b1;
                    state_next      = skm_pkg::S_SRCH_RD;
                end
            end
            skm_pkg::S_SRCH_HRD:
            begin
                ctl.idx_mid = 1'b1;
                state_next  = skm_pkg::S_SRCH_DONE;
            end
            skm_pkg::S_SRCH_DONE:
            begin
                ctl.idx_mid  = 1'b1;
                ctl.out_emit = 1'b1;
                ctl.out_last = 1'b1;
                state_next   = skm_pkg::S_IDLE;
                if (sts.rd_handle_zero)
                begin
                    ctl.out_status = skm_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    ctl.out_status     = skm_pkg::ST_OK;
                    ctl.out_use_handle = 1'b1;
                    ctl.del_write      = (cmd_reg == skm_pkg::CMD_DELETE);
                end
            end
            skm_pkg::S_SQ_RD:
            begin
                ctl.idx_walk = 1'b1;
                if (cmd_reg == skm_pkg::CMD_PICK && sts.no_live)
                begin
                    state_next = skm_pkg::S_EMIT;
                end
                else if (cmd_reg == skm_pkg::CMD_PICK && !sts.has_dead)
                begin
                    ctl.mod_init = 1'b1;
                    state_next   = skm_pkg::S_MOD;
                end
                else if (sts.walk_done)
                begin
                    ctl.sq_finish = 1'b1;
                    if (cmd_reg == skm_pkg::CMD_PICK)
                    begin
                        ctl.mod_init = 1'b1;
                        state_next   = skm_pkg::S_MOD;
                    end
                    else
                    begin
                        ctl.idx_last = 1'b1;
                        state_next   = skm_pkg::S_ADD_RD;
                    end
                end
                else
                begin
                    state_next = skm_pkg::S_SQ_WR;
                end
            end
            skm_pkg::S_SQ_WR:
            begin
                ctl.sq_move   = !sts.rd_handle_zero;
                ctl.walk_step = 1'b1;
                state_next    = skm_pkg::S_SQ_RD;
            end
            skm_pkg::S_MOD:
            begin
                ctl.mod_step = 1'b1;
                if (sts.mod_done)
                begin
                    ctl.mod_step = 1'b0;
                    state_next   = skm_pkg::S_PICK_RD;
                end
            end
            skm_pkg::S_PICK_RD:
            begin
                ctl.idx_pick = 1'b1;
                state_next   = skm_pkg::S_PICK_OUT;
            end
            skm_pkg::S_PICK_OUT:
            begin
                ctl.out_emit       = 1'b1;
                ctl.out_last       = 1'b1;
                ctl.out_status     = skm_pkg::ST_OK;
                ctl.out_use_handle = 1'b1;
                state_next         = skm_pkg::S_IDLE;
            end
            skm_pkg::S_IT_RD:
            begin
                ctl.idx_walk = 1'b1;
                if (sts.walk_done)
                begin
                    state_next = skm_pkg::S_IDLE;
                end
                else
                begin
                    state_next = skm_pkg::S_IT_CHK;
                end
                if (sts.no_live)
                begin
                    state_next = skm_pkg::S_EMIT;
                end
            end
            skm_pkg::S_IT_CHK:
            begin
                ctl.walk_step = 1'b1;
                state_next    = skm_pkg::S_IT_RD;
                if (!sts.rd_handle_zero)
                begin
                    ctl.out_emit       = 1'b1;
                    ctl.out_status     = skm_pkg::ST_OK;
                    ctl.out_use_handle = 1'b1;
                    ctl.out_use_key    = 1'b1;
                    ctl.it_count       = 1'b1;
                    ctl.out_last       = sts.it_final | sts.it_cap;
                    if (sts.it_final || sts.it_cap)
                    begin
                        state_next = skm_pkg::S_IDLE;
                    end
                end
            end
            skm_pkg::S_EMIT:
            begin
                ctl.out_emit = 1'b1;
                ctl.out_last = 1'b1;
                state_next   = skm_pkg::S_IDLE;
                case (cmd_reg)
                    skm_pkg::CMD_DELETE, skm_pkg::CMD_FIND:
                        ctl.out_status = skm_pkg::ST_NOT_FOUND;
                    skm_pkg::CMD_PICK, skm_pkg::CMD_ITERATE:
                        ctl.out_status = skm_pkg::ST_EMPTY;
                    default:
                        ctl.out_status = skm_pkg::ST_OK;
                endcase
            end
            default:
            begin
                state_next = skm_pkg::S_IDLE;
            end
        endcase
    end
endmodule

// ===== hdl/skm_dp.sv =====
// ----------------------------------------------------------------------------
// skm_dp
// Datapath: key/handle memories, counts, search bounds, walk pointers,
// remainder unit and result register.
// ----------------------------------------------------------------------------
module skm_dp #(
    parameter int CAPACITY = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  skm_pkg::ctl_t ctl,
    output skm_pkg::sts_t sts,
    input  logic [31:0]   key,
    input  logic [31:0]   handle,
    input  logic [31:0]   pick,
    output logic          done,
    output logic [2:0]    status,
    output logic [31:0]   found_handle,
    output logic [31:0]   found_key,
    output logic [6:0]    live_count,
    output logic          last
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
    localparam logic [CW-1:0] QUARTER_C = CW'(CAPACITY / 4);
    localparam int MW = CW + 1;

    logic [31:0] key_reg, handle_reg, pick_reg;
    logic [CW-1:0] used_reg, used_next, dead_reg, dead_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] rd_reg, rd_next, wr_reg, wr_next;
    logic [6:0] itn_reg, itn_next;
    logic [MW-1:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [5:0] bit_reg, bit_next;
    logic [CW-1:0] mid;
    logic [CW-1:0] live;
    logic [AW-1:0] addr;
    logic key_we, hnd_we;
    logic [31:0] key_wd, hnd_wd, key_rd, hnd_rd;
    logic [MW-1:0] trial;

    assign live = used_reg - dead_reg;
    assign mid  = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        addr = '0;
        if (ctl.idx_last)
        begin
            addr = AW'(used_reg - CW'(1));
        end
        else if (ctl.idx_mid)
        begin
            addr = mid[AW-1:0];
        end
        else if (ctl.idx_walk)
        begin
            addr = rd_reg[AW-1:0];
        end
        else if (ctl.idx_pick)
        begin
            addr = rem_reg[AW-1:0];
        end
        key_we = 1'b0;
        hnd_we = 1'b0;
        key_wd = key_rd;
        hnd_wd = hnd_rd;
        if (ctl.add_write)
        begin
            addr   = used_reg[AW-1:0];
            key_we = 1'b1;
            hnd_we = 1'b1;
            key_wd = key_reg;
            hnd_wd = handle_reg;
        end
        else if (ctl.del_write)
        begin
            hnd_we = 1'b1;
            hnd_wd = '0;
        end
        else if (ctl.sq_move)
        begin
            addr   = wr_reg[AW-1:0];
            key_we = 1'b1;
            hnd_we = 1'b1;
        end
    end

    skm_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_keys (
        .clk(clk), .we(key_we), .addr(addr), .wdata(key_wd), .rdata(key_rd)
    );
    skm_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_handles (
        .clk(clk), .we(hnd_we), .addr(addr), .wdata(hnd_wd), .rdata(hnd_rd)
    );

    // pick mod used: restoring division, one quotient bit per cycle
    assign trial = {rem_reg[CW-1:0], quo_reg[31]};

    always_comb
    begin
        used_next = used_reg;
        dead_next = dead_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        rd_next   = rd_reg;
        wr_next   = wr_reg;
        itn_next  = itn_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        bit_next  = bit_reg;
        if (ctl.search_init)
        begin
            lo_next = '0;
            hi_next = used_reg;
        end
        if (ctl.search_step)
        begin
            if (sts.mk_lt)
            begin
                lo_next = mid + CW'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
        if (ctl.walk_init)
        begin
            rd_next  = '0;
            wr_next  = '0;
            itn_next = '0;
        end
        if (ctl.walk_step)
        begin
            rd_next = rd_reg + CW'(1);
        end
        if (ctl.sq_move)
        begin
            wr_next = wr_reg + CW'(1);
        end
        if (ctl.it_count)
        begin
            itn_next = itn_reg + 7'd1;
        end
        if (ctl.sq_finish)
        begin
            used_next = wr_reg;
            dead_next = '0;
        end
        if (ctl.add_write)
        begin
            used_next = used_reg + CW'(1);
        end
        if (ctl.del_write)
        begin
            if (dead_reg + CW'(1) == used_reg)
            begin
                used_next = '0;
                dead_next = '0;
            end
            else
            begin
                dead_next = dead_reg + CW'(1);
            end
        end
        if (ctl.mod_init)
        begin
            rem_next = '0;
            quo_next = pick_reg;
            bit_next = 6'd32;
        end
        if (ctl.mod_step)
        begin
            quo_next = {quo_reg[30:0], 1'b0};
            bit_next = bit_reg - 6'd1;
            if (trial >= MW'(used_reg))
            begin
                rem_next = trial - MW'(used_reg);
            end
            else
            begin
                rem_next = trial;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            dead_reg <= '0;
            lo_reg   <= '0;
            hi_reg   <= '0;
            rd_reg   <= '0;
            wr_reg   <= '0;
            itn_reg  <= '0;
            bit_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            dead_reg <= dead_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            rd_reg   <= rd_next;
            wr_reg   <= wr_next;
            itn_reg  <= itn_next;
            bit_reg  <= bit_next;
            done     <= ctl.out_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (ctl.load)
        begin
            key_reg    <= key;
            handle_reg <= handle;
            pick_reg   <= pick;
        end
        if (ctl.out_emit)
        begin
            status       <= ctl.out_status;
            found_handle <= ctl.out_use_handle ? hnd_rd : 32'd0;
            found_key    <= ctl.out_use_key ? key_rd : key_reg;
            live_count   <= 7'(used_next - dead_next);
            last         <= ctl.out_last;
        end
    end

    always_comb
    begin
        sts                = '0;
        sts.used_zero      = (used_reg == '0);
        sts.used_full      = (used_reg >= CAP_C);
        sts.dead_over      = (dead_reg > QUARTER_C);
        sts.no_live        = (live == '0);
        sts.has_dead       = (dead_reg != '0);
        sts.key_le         = (key_rd >= key_reg);
        sts.handle_zero    = (handle_reg == 32'd0);
        sts.rd_handle_zero = (hnd_rd == 32'd0);
        sts.search_done    = (lo_reg >= hi_reg);
        sts.mk_lt          = (key_rd < key_reg);
        sts.mk_eq          = (key_rd == key_reg);
        sts.walk_done      = (rd_reg >= used_reg);
        sts.mod_done       = (bit_reg == 6'd0);
        sts.it_cap         = (itn_reg == 7'(skm_pkg::MAX_RESULTS - 1));
        // live entries already emitted plus this one cover the table
        sts.it_final       = ((CW'(itn_reg) + CW'(1)) == live);
    end
endmodule

// ===== hdl/sorted_key_map_with_tombstones_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_key_map_with_tombstones_unit
// Sorted key/handle table with lazy delete, binary search and compaction.
// ----------------------------------------------------------------------------
//  channel   | signals                                | transfer
//  ----------+----------------------------------------+-----------------------
//  command   | start, busy, command, key, handle, pick| start & !busy
//  result    | done, status, found_handle, found_key, | done (one cycle)
//            | live_count, last                       |
//
// Find/delete: at most log2(CAPACITY)+1 binary-search probes, each a key
// read and compare on the single-port key/handle RAMs, then a handle read.
// Add: reads the last used key, checks and writes; a full table with more
// than CAPACITY/4 tombstones is compacted first.
// Pick: compaction walk over the used slots (skipped without tombstones),
// then the remainder of pick by used and the read. Iterate: walks the
// slots up to the last live one, one result per live slot. Reset clears
// counts, bounds and pointers, not the RAMs; the result receiver cannot
// stall, busy holds off new commands.
// ----------------------------------------------------------------------------
module sorted_key_map_with_tombstones_unit #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [31:0] key,
    input  logic [31:0] handle,
    input  logic [31:0] pick,
    output logic        done,
    output logic [2:0]  status,
    output logic [31:0] found_handle,
    output logic [31:0] found_key,
    output logic [6:0]  live_count,
    output logic        last
);
    skm_pkg::ctl_t ctl;
    skm_pkg::sts_t sts;

    skm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .command(command),
        .sts(sts), .ctl(ctl), .busy(busy)
    );

    skm_dp #(.CAPACITY(CAPACITY)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
        .key(key), .handle(handle), .pick(pick),
        .done(done), .status(status), .found_handle(found_handle),
        .found_key(found_key), .live_count(live_count), .last(last)
    );

`ifndef SYNTHESIS
    // the final result of a command returns the block to idle
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_emit && ctl.out_last |=> !busy)
        else $error("final result left block busy");

    a_no_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result in cycle after accept");

    a_live_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> live_count <= 7'(CAPACITY))
        else $error("live count above capacity");
`endif
endmodule

// ===== test/sorted_key_map_with_tombstones_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_key_map_with_tombstones_unit_tb
// Self-checking bench for the sorted key map: a directed table of commands,
// then random add/delete/find/pick/iterate traffic with random start gaps.
// Every result is checked against an in-bench model of the table or a typed-in result.
// ----------------------------------------------------------------------------
module sorted_key_map_with_tombstones_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 64;
    // command codes the block ignores
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  command = '0;
    logic [31:0] key = '0;
    logic [31:0] handle = '0;
    logic [31:0] pick = '0;
    logic        done;
    logic [2:0]  status;
    logic [31:0] found_handle;
    logic [31:0] found_key;
    logic [6:0]  live_count;
    logic        last;

    always #5 clk = ~clk;

    sorted_key_map_with_tombstones_unit #(.CAPACITY(SLOTS)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .key(key), .handle(handle), .pick(pick),
        .done(done), .status(status), .found_handle(found_handle),
        .found_key(found_key), .live_count(live_count), .last(last)
    );

    typedef struct {
        logic [2:0]  status;
        logic [31:0] handle;
        logic [31:0] key;
        logic [6:0]  live;
        logic        last;
    } map_result_t;

    map_result_t pending_results[$];
    int          mismatches = 0;

    // ---------------------------------------------------------------- model
    // Shadow copy of the table. Slots at or above map_used are never read.
    logic [31:0] map_keys    [SLOTS];
    logic [31:0] map_handles [SLOTS];
    int unsigned map_used = 0;
    int unsigned map_dead = 0;

    function automatic void expect_result(logic [2:0] st, logic [31:0] h,
                                          logic [31:0] k, logic lst);
        map_result_t r;
        r.status = st;
        r.handle = h;
        r.key    = k;
        r.live   = 7'(map_used - map_dead);
        r.last   = lst;
        pending_results.push_back(r);
    endfunction

    // squeeze tombstones out, order kept
    function automatic void compact_map();
        int unsigned wr;
        wr = 0;
        for (int unsigned rd = 0; rd < map_used; rd++)
        begin
            if (map_handles[rd] != 0)
            begin
                map_keys[wr]    = map_keys[rd];
                map_handles[wr] = map_handles[rd];
                wr++;
            end
        end
        map_used = wr;
        map_dead = 0;
    endfunction

    function automatic int search_slot(logic [31:0] k);
        int unsigned lo, hi, mid;
        lo = 0;
        hi = map_used;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (map_keys[mid] < k)      lo = mid + 1;
            else if (map_keys[mid] > k) hi = mid;
            else return int'(mid);
        end
        return -1;
    endfunction

    // Applies one command to the shadow table and queues its results.
    function automatic void apply_map_command(logic [2:0] c, logic [31:0] k,
                                              logic [31:0] h, logic [31:0] p);
        int          slot;
        int          n;
        logic [31:0] old;
        map_result_t tail;
        n = 0;
        case (c)
            skm_pkg::CMD_ADD:
            begin
                if (map_used != 0 && map_keys[map_used-1] >= k)
                    expect_result(skm_pkg::ST_ORDER, '0, k, 1'b1);
                else if (h == 0)
                    expect_result(skm_pkg::ST_ZERO_HANDLE, '0, k, 1'b1);
                else if (map_used >= SLOTS && map_dead <= SLOTS / 4)
                    expect_result(skm_pkg::ST_FULL, '0, k, 1'b1);
                else
                begin
                    if (map_used >= SLOTS)
                        compact_map();
                    map_keys[map_used]    = k;
                    map_handles[map_used] = h;
                    map_used++;
                    expect_result(skm_pkg::ST_OK, '0, k, 1'b1);
                end
            end
            skm_pkg::CMD_DELETE:
            begin
                slot = search_slot(k);
                if (slot < 0)
                    expect_result(skm_pkg::ST_NOT_FOUND, '0, k, 1'b1);
                else
                begin
                    old = map_handles[slot];
                    map_handles[slot] = '0;
                    if (old != 0) map_dead++;
                    // last live entry gone: table starts over
                    if (map_dead == map_used)
                    begin
                        map_dead = 0;
                        map_used = 0;
                    end
                    expect_result(old != 0 ? skm_pkg::ST_OK : skm_pkg::ST_NOT_FOUND,
                                  old, k, 1'b1);
                end
            end
            skm_pkg::CMD_FIND:
            begin
                slot = search_slot(k);
                if (slot < 0 || map_handles[slot] == 0)
                    expect_result(skm_pkg::ST_NOT_FOUND, '0, k, 1'b1);
                else
                    expect_result(skm_pkg::ST_OK, map_handles[slot], k, 1'b1);
            end
            skm_pkg::CMD_PICK:
            begin
                if (map_used == map_dead)
                    expect_result(skm_pkg::ST_EMPTY, '0, k, 1'b1);
                else
                begin
                    if (map_dead != 0) compact_map();
                    expect_result(skm_pkg::ST_OK, map_handles[p % map_used], k, 1'b1);
                end
            end
            skm_pkg::CMD_ITERATE:
            begin
                for (int unsigned i = 0; i < map_used && n < skm_pkg::MAX_RESULTS; i++)
                begin
                    if (map_handles[i] != 0)
                    begin
                        expect_result(skm_pkg::ST_OK, map_handles[i], map_keys[i], 1'b0);
                        n++;
                    end
                end
                if (n == 0)
                    expect_result(skm_pkg::ST_EMPTY, '0, k, 1'b1);
                else
                begin
                    tail = pending_results.pop_back();
                    tail.last = 1'b1;
                    pending_results.push_back(tail);
                end
            end
            default: expect_result(skm_pkg::ST_OK, '0, k, 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------ checking
    // Results cannot be held off: each done pulse is one transfer.
    always @(posedge clk)
    begin
        map_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: status %0d handle %h key %h",
                       status, found_handle, found_key);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
                if (found_handle !== want.handle)
                begin
                    $error("found_handle: expected %h, got %h", want.handle, found_handle);
                    mismatches++;
                end
                if (found_key !== want.key)
                begin
                    $error("found_key: expected %h, got %h", want.key, found_key);
                    mismatches++;
                end
                if (live_count !== want.live)
                begin
                    $error("live_count: expected %0d, got %0d", want.live, live_count);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------- driving
    bit quiet_burst = 1'b0;  // a stretch with back-to-back commands

    // Holds start high until the command transfer happens (start & !busy at
    // an edge), then updates the model. If typed is set the single result is
    // the typed one rather than the model's.
    task automatic send_command(logic [2:0] c, logic [31:0] k, logic [31:0] h,
                                logic [31:0] p, bit typed = 1'b0,
                                logic [2:0] t_st = '0, logic [31:0] t_h = '0,
                                logic [6:0] t_live = '0);
        int unsigned gap;
        map_result_t r;
        start   <= 1'b1;
        command <= c;
        key     <= k;
        handle  <= h;
        pick    <= p;
        do @(posedge clk); while (busy);
        apply_map_command(c, k, h, p);
        if (typed)
        begin
            void'(pending_results.pop_back());
            r.status = t_st;
            r.handle = t_h;
            r.key    = k;
            r.live   = t_live;
            r.last   = 1'b1;
            pending_results.push_back(r);
        end
        // idle gap: mostly none or short, now and then long
        gap = $urandom_range(0, 99);
        if (quiet_burst || gap < 45)  gap = 0;
        else if (gap < 90)            gap = $urandom_range(1, 3);
        else                          gap = $urandom_range(8, 40);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Directed table: corner rows carry their expected result typed in.
    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] k;
        logic [31:0] h;
        logic [31:0] p;
        bit          typed;
        logic [2:0]  st;
        logic [31:0] fh;
        logic [6:0]  live;
    } directed_row_t;

    directed_row_t directed_rows[] = '{
        '{skm_pkg::CMD_ITERATE, 32'h1234_5678, 32'h0, 32'h0, 1,
          skm_pkg::ST_EMPTY, 32'h0, 7'd0},
        '{skm_pkg::CMD_PICK, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1,
          skm_pkg::ST_EMPTY, 32'h0, 7'd0},
        '{skm_pkg::CMD_FIND, 32'h0, 32'h0, 32'h0, 1, skm_pkg::ST_NOT_FOUND, 32'h0, 7'd0},
        '{skm_pkg::CMD_DELETE, 32'h0, 32'h0, 32'h0, 1, skm_pkg::ST_NOT_FOUND, 32'h0, 7'd0},
        '{skm_pkg::CMD_ADD, 32'h0, 32'h0, 32'h0, 1, skm_pkg::ST_ZERO_HANDLE, 32'h0, 7'd0},
        '{skm_pkg::CMD_ADD, 32'h0, 32'hFFFF_FFFF, 32'h0, 1, skm_pkg::ST_OK, 32'h0, 7'd1},
        '{skm_pkg::CMD_ADD, 32'h0, 32'h1, 32'h0, 1, skm_pkg::ST_ORDER, 32'h0, 7'd1},
        '{skm_pkg::CMD_FIND, 32'h0, 32'h0, 32'h0, 1, skm_pkg::ST_OK, 32'hFFFF_FFFF, 7'd1},
        '{skm_pkg::CMD_DELETE, 32'h0, 32'h0, 32'h0, 1, skm_pkg::ST_OK, 32'hFFFF_FFFF, 7'd0},
        '{skm_pkg::CMD_ADD, 32'h10, 32'hA5A5_0001, 32'h0, 0, skm_pkg::ST_OK, 32'h0, 7'd0},
        '{skm_pkg::CMD_ADD, 32'h20, 32'h5A5A_0002, 32'h0, 0, skm_pkg::ST_OK, 32'h0, 7'd0},
        '{skm_pkg::CMD_ADD, 32'h30, 32'h0000_0003, 32'h0, 0, skm_pkg::ST_OK, 32'h0, 7'd0},
        '{skm_pkg::CMD_ADD, 32'h20, 32'h0000_0009, 32'h0, 0, skm_pkg::ST_OK, 32'h0, 7'd0},
        '{skm_pkg::CMD_DELETE, 32'h20, 32'h0, 32'h0, 0, skm_pkg::ST_OK, 32'h0, 7'd0},
        // a tombstone's slot reads as missing
        '{skm_pkg::CMD_DELETE, 32'h20, 32'h0, 32'h0, 0, skm_pkg::ST_OK, 32'h0, 7'd0},
        '{skm_pkg::CMD_FIND, 32'h20, 32'h0, 32'h0, 0, skm_pkg::ST_OK, 32'h0, 7'd0},
        '{skm_pkg::CMD_ITERATE, 32'h0, 32'h0, 32'h0, 0, skm_pkg::ST_OK, 32'h0, 7'd0},
        '{skm_pkg::CMD_PICK, 32'h0, 32'h0, 32'hFFFF_FFFF, 0, skm_pkg::ST_OK, 32'h0, 7'd0},
        '{CMD_RSVD5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
          skm_pkg::ST_OK, 32'h0, 7'd2},
        '{CMD_RSVD6, 32'h0, 32'h0, 32'h0, 1, skm_pkg::ST_OK, 32'h0, 7'd2},
        '{CMD_RSVD7, 32'h5555_AAAA, 32'h0, 32'h0, 1, skm_pkg::ST_OK, 32'h0, 7'd2},
        '{skm_pkg::CMD_DELETE, 32'h10, 32'h0, 32'h0, 0, skm_pkg::ST_OK, 32'h0, 7'd0},
        '{skm_pkg::CMD_DELETE, 32'h30, 32'h0, 32'h0, 0, skm_pkg::ST_OK, 32'h0, 7'd0},
        // top key; then empty the table so later keys can climb again
        '{skm_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 1,
          skm_pkg::ST_OK, 32'h0, 7'd1},
        '{skm_pkg::CMD_DELETE, 32'hFFFF_FFFF, 32'h0, 32'h0, 1,
          skm_pkg::ST_OK, 32'h8000_0000, 7'd0}
    };

    initial
    begin
        logic [31:0] next_key;
        logic [31:0] k;
        logic [2:0]  c;
        int unsigned roll;
        int unsigned added;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_command(directed_rows[i].cmd, directed_rows[i].k, directed_rows[i].h,
                         directed_rows[i].p, directed_rows[i].typed,
                         directed_rows[i].st, directed_rows[i].fh, directed_rows[i].live);

        // Random part: keys climb so adds mostly land, the table gets
        // tombstones and compacts. Range keeps the climb below the top of
        // the key space.
        next_key = $urandom_range(0, 32'h7FFF_FFFF);
        added = 0;
        for (int n = 0; n < 95; n++)
        begin
            if (n % 20 == 0) quiet_burst = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            k    = $urandom;
            if (roll < 55)
            begin
                c = skm_pkg::CMD_ADD;
                next_key = next_key + $urandom_range(1, 32'h007F_FFFF);
                k = next_key;
            end
            else if (roll < 75) c = skm_pkg::CMD_DELETE;
            else if (roll < 87) c = skm_pkg::CMD_FIND;
            else if (roll < 93) c = skm_pkg::CMD_PICK;
            else if (roll < 96) c = skm_pkg::CMD_ITERATE;
            else                c = 3'($urandom_range(0, 7));
            // lookups mostly hit stored keys, live or dead
            if ((c == skm_pkg::CMD_DELETE || c == skm_pkg::CMD_FIND) && map_used != 0 &&
                $urandom_range(0, 9) < 8)
                k = map_keys[$urandom_range(0, map_used - 1)];
            // a few broken adds: stale key or zero handle
            if (c == skm_pkg::CMD_ADD && $urandom_range(0, 19) == 0 && map_used != 0)
                k = map_keys[map_used - 1];
            send_command(c, k, ($urandom_range(0, 29) == 0) ? 32'h0 : $urandom,
                         $urandom);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        // an extra pulse would show up here
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
